>>> hw/rtl/bdpc_pkg.sv
// Package for the brush dab pixel compositor.
// Holds register indexes, blend modes, control structs and the divide-by-255 helper.
// No dependencies.
package bdpc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BRUSH_COLOR   = 3'd0,
    REG_OPACITY       = 3'd1,
    REG_FLOW          = 3'd2,
    REG_WET_MIX       = 3'd3,
    REG_PROTECT_ALPHA = 3'd4,
    REG_LAYER_LOCKED  = 3'd5
  } reg_idx_e;

  // Blend mode of a written pixel
  typedef enum logic [1:0] {
    MODE_ERASE   = 2'd0,
    MODE_PROTECT = 2'd1,
    MODE_NORMAL  = 2'd2
  } mode_e;

  // Flags derived from the configuration registers
  typedef struct packed {
    logic erase;
    logic protect;
    logic locked;
    logic wet_on;
  } cfg_flags_t;

  // Per-pixel control that travels down the pipeline
  typedef struct packed {
    logic  wr;
    mode_e mode;
  } pix_ctl_t;

  localparam int unsigned CfgIndexBits = 3;
  localparam int unsigned CfgDataBits  = 32;

  // Floor of x / 255: refine x/256 estimates, then one correction step
  function automatic logic [31:0] div255(input logic [31:0] x);
    logic [32:0] xw;
    logic [32:0] q0;
    logic [32:0] q1;
    logic [32:0] q2;
    logic [32:0] q3;
    logic [32:0] r;
    xw = {1'b0, x};
    q0 = xw >> 8;
    q1 = (xw + q0) >> 8;
    q2 = (xw + q1) >> 8;
    q3 = (xw + q2) >> 8;
    r  = xw - ((q3 << 8) - q3);
    if (r >= 33'd255) begin
      q3 = q3 + 33'd1;
    end
    return q3[31:0];
  endfunction

endpackage

>>> hw/rtl/bdpc_cfg.sv
// Configuration registers of the compositor and values derived from them.
// Depends on bdpc_pkg (register indexes, flags struct, div255).
module bdpc_cfg import bdpc_pkg::*; #(
  parameter int unsigned CB = 10,
  parameter int unsigned FB = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  output logic [FB:0]             af_o,
  output logic [2:0][CB-1:0]      src_o,
  output logic [FB:0]             w_o,
  output logic [FB:0]             wn_o,
  output logic [FB:0]             opacity_o,
  output logic [FB:0]             flow_o,
  output cfg_flags_t              flags_o
);

  localparam logic [FB:0] One = {1'b1, {FB{1'b0}}};

  logic [31:0] brush_q;
  logic [FB:0] opacity_q;
  logic [FB:0] flow_q;
  logic [FB:0] wet_q;
  logic        protect_q;
  logic        locked_q;

  logic [FB:0]          af_d, af_q;
  logic [2:0][CB-1:0]   src_d, src_q;
  logic [FB:0]          w_d, w_q;
  logic [FB:0]          wn_d, wn_q;
  cfg_flags_t           flags_d, flags_q;

  assign cfg_ready_o = 1'b1;

  // Take one register beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brush_q   <= '0;
      opacity_q <= One;
      flow_q    <= One;
      wet_q     <= '0;
      protect_q <= 1'b0;
      locked_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_BRUSH_COLOR:   brush_q   <= cfg_data_i;
        REG_OPACITY:       opacity_q <= cfg_data_i[FB:0];
        REG_FLOW:          flow_q    <= cfg_data_i[FB:0];
        REG_WET_MIX:       wet_q     <= cfg_data_i[FB:0];
        REG_PROTECT_ALPHA: protect_q <= cfg_data_i[0];
        REG_LAYER_LOCKED:  locked_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Derive brush alpha factor, widened colour and wet weights
  always_comb begin
    logic [7:0]  ba;
    logic [31:0] af_x;
    logic [31:0] af_full;
    logic [31:0] cx;
    logic [31:0] sx;
    logic [FB:0] wsat;
    ba      = brush_q[31:24];
    flags_d.erase   = (ba == 8'd0) && !protect_q;
    flags_d.protect = protect_q;
    flags_d.locked  = locked_q;
    flags_d.wet_on  = (wet_q != '0);
    af_x    = ({24'd0, ba} << FB) + 32'd127;
    af_full = div255(af_x);
    af_d    = flags_d.erase ? One : af_full[FB:0];
    for (int i = 0; i < 3; i++) begin
      cx = {24'd0, brush_q[16-8*i +: 8]};
      sx = div255((cx << CB) - cx + 32'd127);
      src_d[i] = sx[CB-1:0];
    end
    wsat = (wet_q > One) ? One : wet_q;
    w_d  = wsat;
    wn_d = One - wsat;
  end

  // Refresh derived values every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    af_q  <= af_d;
    src_q <= src_d;
    w_q   <= w_d;
    wn_q  <= wn_d;
  end

  assign af_o      = af_q;
  assign src_o     = src_q;
  assign w_o       = w_q;
  assign wn_o      = wn_q;
  assign opacity_o = opacity_q;
  assign flow_o    = flow_q;
  assign flags_o   = flags_q;

endmodule

>>> hw/rtl/bdpc_alpha.sv
// Front stages: input register, effective alpha chain, wet mix and dst*alpha product.
// Depends on bdpc_pkg (flags, control struct, modes).
module bdpc_alpha import bdpc_pkg::*; #(
  parameter int unsigned CB = 10,
  parameter int unsigned FB = 16
) (
  input  logic                    clk_i,
  input  logic [4:0]              ld_i,
  input  logic [2:0][CB-1:0]      dst_i,
  input  logic [CB-1:0]           dst_alpha_i,
  input  logic [FB:0]             coverage_i,
  input  logic                    selected_i,
  input  logic [FB:0]             af_i,
  input  logic [2:0][CB-1:0]      src_i,
  input  logic [FB:0]             w_i,
  input  logic [FB:0]             wn_i,
  input  logic [FB:0]             opacity_i,
  input  logic [FB:0]             flow_i,
  input  cfg_flags_t              flags_i,
  output logic [2:0][CB-1:0]      d_o,
  output logic [CB-1:0]           da_o,
  output logic [2:0][CB-1:0]      s_o,
  output logic [2:0][2*CB-1:0]    dd_o,
  output logic [FB:0]             alpha_o,
  output pix_ctl_t                ctl_o
);

  localparam int unsigned OneInt    = 1 << FB;
  localparam logic [FB:0]   One      = {1'b1, {FB{1'b0}}};
  localparam logic [FB+3:0] OneWide  = (FB+4)'(OneInt);
  localparam logic [FB+3:0] MinAlpha = (FB+4)'(OneInt / 100);

  // stage 0
  logic [2:0][CB-1:0] d0_q;
  logic [CB-1:0]      da0_q;
  logic [FB:0]        cov0_q;
  logic               sel0_q;
  // stage 1
  logic [2:0][CB-1:0]   d1_q;
  logic [CB-1:0]        da1_q;
  logic [FB+1:0]        a1_q;
  logic                 kill1_q;
  mode_e                mode1_q;
  logic [2:0][CB+FB:0]  ps1_q, pd1_q;
  // stage 2
  logic [2:0][CB-1:0] d2_q, s2_q;
  logic [CB-1:0]      da2_q;
  logic [FB+2:0]      a2_q;
  logic               kill2_q;
  mode_e              mode2_q;
  // stage 3
  logic [2:0][CB-1:0]   d3_q, s3_q;
  logic [CB-1:0]        da3_q;
  logic [FB+3:0]        a3_q;
  logic                 kill3_q;
  mode_e                mode3_q;
  logic [2:0][2*CB-1:0] dd3_q;
  // stage 4
  logic [2:0][CB-1:0]   d4_q, s4_q;
  logic [CB-1:0]        da4_q;
  logic [2:0][2*CB-1:0] dd4_q;
  logic [FB:0]          alpha4_q;
  pix_ctl_t             ctl4_q;

  logic [2*FB+1:0]      m1;
  logic [2*FB+2:0]      m2;
  logic [2*FB+3:0]      m3;
  logic [2:0][CB+FB:0]  ps_d, pd_d;
  logic [2:0][CB-1:0]   sw_d;
  logic [2:0][2*CB-1:0] dd_d;
  logic                 kill1_d;
  mode_e                mode1_d;
  logic [FB:0]          alpha4_d;
  pix_ctl_t             ctl4_d;

  // Per-stage arithmetic
  always_comb begin
    logic [CB+FB+1:0] wsum;
    m1 = af_i * cov0_q;
    m2 = a1_q * opacity_i;
    m3 = a2_q * flow_i;
    kill1_d = flags_i.locked || !sel0_q || (cov0_q == '0);
    if (flags_i.erase) begin
      mode1_d = MODE_ERASE;
    end else if (flags_i.protect) begin
      mode1_d = MODE_PROTECT;
    end else begin
      mode1_d = MODE_NORMAL;
    end
    for (int i = 0; i < 3; i++) begin
      ps_d[i] = src_i[i] * wn_i;
      pd_d[i] = d0_q[i] * w_i;
      wsum    = (CB+FB+2)'(ps1_q[i]) + (CB+FB+2)'(pd1_q[i]);
      sw_d[i] = (flags_i.wet_on && (da1_q != '0)) ? wsum[CB+FB-1:FB] : src_i[i];
      dd_d[i] = d2_q[i] * da2_q;
    end
    alpha4_d    = (a3_q > OneWide) ? One : a3_q[FB:0];
    ctl4_d.wr   = !kill3_q && (a3_q > MinAlpha);
    ctl4_d.mode = mode3_q;
  end

  // Advance each stage when its load enable is set
  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      d0_q   <= dst_i;
      da0_q  <= dst_alpha_i;
      cov0_q <= coverage_i;
      sel0_q <= selected_i;
    end
    if (ld_i[1]) begin
      d1_q    <= d0_q;
      da1_q   <= da0_q;
      a1_q    <= m1[2*FB+1:FB];
      kill1_q <= kill1_d;
      mode1_q <= mode1_d;
      ps1_q   <= ps_d;
      pd1_q   <= pd_d;
    end
    if (ld_i[2]) begin
      d2_q    <= d1_q;
      da2_q   <= da1_q;
      s2_q    <= sw_d;
      a2_q    <= m2[2*FB+2:FB];
      kill2_q <= kill1_q;
      mode2_q <= mode1_q;
    end
    if (ld_i[3]) begin
      d3_q    <= d2_q;
      da3_q   <= da2_q;
      s3_q    <= s2_q;
      a3_q    <= m3[2*FB+3:FB];
      kill3_q <= kill2_q;
      mode3_q <= mode2_q;
      dd3_q   <= dd_d;
    end
    if (ld_i[4]) begin
      d4_q     <= d3_q;
      da4_q    <= da3_q;
      s4_q     <= s3_q;
      dd4_q    <= dd3_q;
      alpha4_q <= alpha4_d;
      ctl4_q   <= ctl4_d;
    end
  end

  assign d_o     = d4_q;
  assign da_o    = da4_q;
  assign s_o     = s4_q;
  assign dd_o    = dd4_q;
  assign alpha_o = alpha4_q;
  assign ctl_o   = ctl4_q;

endmodule

>>> hw/rtl/bdpc_blend.sv
// Blend stages: weight products, then erase/protect results and divider operands.
// Depends on bdpc_pkg (control struct, modes).
module bdpc_blend import bdpc_pkg::*; #(
  parameter int unsigned CB = 10,
  parameter int unsigned FB = 16
) (
  input  logic                          clk_i,
  input  logic [1:0]                    ld_i,
  input  logic [2:0][CB-1:0]            d_i,
  input  logic [CB-1:0]                 da_i,
  input  logic [2:0][CB-1:0]            s_i,
  input  logic [2:0][2*CB-1:0]          dd_i,
  input  logic [FB:0]                   alpha_i,
  input  pix_ctl_t                      ctl_i,
  output logic [2:0][CB-1:0]            pre_col_o,
  output logic [CB-1:0]                 pre_a_o,
  output pix_ctl_t                      ctl_o,
  output logic [2:0][2*CB+FB:0]         num_o,
  output logic [CB+FB:0]                den_o
);

  localparam int unsigned NW = 2*CB + FB + 1;
  localparam logic [FB:0] One = {1'b1, {FB{1'b0}}};

  // stage 5
  logic [2:0][CB-1:0]   d5_q;
  logic [CB-1:0]        da5_q;
  pix_ctl_t             ctl5_q;
  logic [2:0][CB+FB:0]  sa5_q, dr5_q;
  logic [CB+FB:0]       dar5_q, ac5_q;
  logic [2:0][NW-1:0]   ddr5_q;
  // stage 6
  logic [2:0][CB-1:0]   pre_col_q;
  logic [CB-1:0]        pre_a_q;
  pix_ctl_t             ctl6_q;
  logic [2:0][NW-1:0]   num_q;
  logic [CB+FB:0]       den_q;

  logic [FB:0]          rest;
  logic [CB+FB:0]       aw;
  logic [2:0][CB+FB:0]  sa_d, dr_d;
  logic [CB+FB:0]       dar_d, ac_d;
  logic [2:0][NW-1:0]   ddr_d;

  // Products against alpha and its complement
  always_comb begin
    rest  = One - alpha_i;
    aw    = (CB+FB+1)'(alpha_i);
    ac_d  = (aw << CB) - aw;
    dar_d = da_i * rest;
    for (int i = 0; i < 3; i++) begin
      sa_d[i]  = s_i[i] * alpha_i;
      dr_d[i]  = d_i[i] * rest;
      ddr_d[i] = dd_i[i] * rest;
    end
  end

  logic [2:0][CB-1:0] pre_col_d;
  logic [CB-1:0]      pre_a_d;
  logic [2:0][NW-1:0] num_d;
  logic [CB+FB:0]     den_d;

  // Finish the non-dividing modes and form the blend quotient operands
  always_comb begin
    logic [CB+FB+1:0]   psum;
    logic [2:0][CB-1:0] colp;
    logic [CB-1:0]      na;
    logic [NW-1:0]      saw;
    na    = dar5_q[CB+FB-1:FB];
    den_d = ac5_q + dar5_q;
    for (int i = 0; i < 3; i++) begin
      psum     = (CB+FB+2)'(dr5_q[i]) + (CB+FB+2)'(sa5_q[i]);
      colp[i]  = psum[CB+FB-1:FB];
      saw      = NW'(sa5_q[i]);
      num_d[i] = (saw << CB) - saw + ddr5_q[i];
    end
    pre_col_d = d5_q;
    pre_a_d   = da5_q;
    if (ctl5_q.wr) begin
      case (ctl5_q.mode)
        MODE_ERASE: begin
          pre_col_d = (na == '0) ? '0 : d5_q;
          pre_a_d   = na;
        end
        MODE_PROTECT: begin
          pre_col_d = colp;
        end
        MODE_NORMAL: begin
          pre_a_d = den_d[CB+FB-1:FB];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      d5_q   <= d_i;
      da5_q  <= da_i;
      ctl5_q <= ctl_i;
      sa5_q  <= sa_d;
      dr5_q  <= dr_d;
      dar5_q <= dar_d;
      ac5_q  <= ac_d;
      ddr5_q <= ddr_d;
    end
    if (ld_i[1]) begin
      pre_col_q <= pre_col_d;
      pre_a_q   <= pre_a_d;
      ctl6_q    <= ctl5_q;
      num_q     <= num_d;
      den_q     <= den_d;
    end
  end

  assign pre_col_o = pre_col_q;
  assign pre_a_o   = pre_a_q;
  assign ctl_o     = ctl6_q;
  assign num_o     = num_q;
  assign den_o     = den_q;

endmodule

>>> hw/rtl/bdpc_div.sv
// Pipelined restoring divider: one quotient bit per stage, three channels share a divisor.
// Depends on bdpc_pkg; side data rides along with each stage.
module bdpc_div import bdpc_pkg::*; #(
  parameter int unsigned CB = 10,
  parameter int unsigned FB = 16,
  parameter int unsigned SW = 42
) (
  input  logic                   clk_i,
  input  logic [CB-1:0]          ld_i,
  input  logic [2:0][2*CB+FB:0]  num_i,
  input  logic [CB+FB:0]         den_i,
  input  logic [SW-1:0]          side_i,
  output logic [2:0][CB-1:0]     quo_o,
  output logic [SW-1:0]          side_o
);

  localparam int unsigned NW = 2*CB + FB + 1;
  localparam int unsigned DW = CB + FB + 1;

  logic [2:0][NW-1:0] rem_q  [CB-1];
  logic [DW-1:0]      den_q  [CB-1];
  logic [2:0][CB-1:0] quo_q  [CB];
  logic [SW-1:0]      side_q [CB];

  for (genvar j = 0; j < CB; j++) begin : g_stage
    localparam int unsigned B = CB - 1 - j;

    logic [2:0][NW-1:0] rem_in, rem_d;
    logic [2:0][CB-1:0] quo_in, quo_d;
    logic [DW-1:0]      den_in;
    logic [SW-1:0]      side_in;
    logic [NW-1:0]      dsh;

    if (j == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    // Try to subtract the shifted divisor
    always_comb begin
      dsh = NW'(den_in) << B;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dsh) begin
          rem_d[i] = rem_in[i] - dsh;
          quo_d[i] = quo_in[i] | (CB'(1) << B);
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = quo_in[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld_i[j]) begin
        quo_q[j]  <= quo_d;
        side_q[j] <= side_in;
      end
    end

    if (j < CB - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (ld_i[j]) begin
          rem_q[j] <= rem_d;
          den_q[j] <= den_in;
        end
      end
    end
  end

  assign quo_o  = quo_q[CB-1];
  assign side_o = side_q[CB-1];

endmodule

>>> hw/rtl/brush_dab_pixel_compositor.sv
// Top level of the brush dab pixel compositor: pipeline control and output select.
// Depends on bdpc_pkg, bdpc_cfg, bdpc_alpha, bdpc_blend, bdpc_div.
//
//   port group    direction  handshake                 beat
//   in            sink       in_valid_i / in_stall_o   dst pixel, coverage, selected
//   out           source     out_valid_o / out_stall_i new pixel, write_enable
//   cfg           sink       cfg_valid_i / cfg_ready_o register index and data
//
// The pipe holds CHANNEL_BITS + 7 register stages (17 at defaults): five front stages, two
// blend stages and one divider stage per quotient bit. An accepted beat moves through them in
// that order to the output. One pixel enters every cycle while in_stall_o is low.
// Reset clears all valid bits and sets the registers to their defaults; cfg is always ready.
// A stall holds the output beat; upstream stages keep filling bubbles until the pipe is full.
module brush_dab_pixel_compositor import bdpc_pkg::*; #(
  parameter int unsigned CHANNEL_BITS  = 10,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIndexBits-1:0]   cfg_index_i,
  input  logic [CfgDataBits-1:0]    cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CHANNEL_BITS-1:0]   dst_red_i,
  input  logic [CHANNEL_BITS-1:0]   dst_green_i,
  input  logic [CHANNEL_BITS-1:0]   dst_blue_i,
  input  logic [CHANNEL_BITS-1:0]   dst_alpha_i,
  input  logic [FRACTION_BITS:0]    coverage_i,
  input  logic                      selected_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [CHANNEL_BITS-1:0]   out_red_o,
  output logic [CHANNEL_BITS-1:0]   out_green_o,
  output logic [CHANNEL_BITS-1:0]   out_blue_o,
  output logic [CHANNEL_BITS-1:0]   out_alpha_o,
  output logic                      write_enable_o
);

  localparam int unsigned CB  = CHANNEL_BITS;
  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned NST = CB + 7;
  localparam int unsigned SW  = 4*CB + $bits(pix_ctl_t);

  logic [FB:0]          af, w, wn, opacity, flow;
  logic [2:0][CB-1:0]   src;
  cfg_flags_t           flags;

  logic [NST-1:0]       v_q;
  logic [NST-1:0]       ld;

  logic [2:0][CB-1:0]   dst;
  logic [2:0][CB-1:0]   d4, s4;
  logic [CB-1:0]        da4;
  logic [2:0][2*CB-1:0] dd4;
  logic [FB:0]          alpha4;
  pix_ctl_t             ctl4;

  logic [2:0][CB-1:0]      pre_col6;
  logic [CB-1:0]           pre_a6;
  pix_ctl_t                ctl6;
  logic [2:0][2*CB+FB:0]   num6;
  logic [CB+FB:0]          den6;

  logic [SW-1:0]        side_in, side_out;
  logic [2:0][CB-1:0]   quo;
  logic [2:0][CB-1:0]   pre_col_out;
  logic [CB-1:0]        pre_a_out;
  pix_ctl_t             ctl_out;
  logic                 use_quo;

  assign dst = {dst_blue_i, dst_green_i, dst_red_i};

  bdpc_cfg #(.CB(CB), .FB(FB)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .af_o        (af),
    .src_o       (src),
    .w_o         (w),
    .wn_o        (wn),
    .opacity_o   (opacity),
    .flow_o      (flow),
    .flags_o     (flags)
  );

  // A stage loads unless it and every stage after it is full and the output stalls
  always_comb begin
    logic [NST-1:0] mask;
    for (int k = 0; k < NST; k++) begin
      mask  = {NST{1'b1}} >> (NST - k);
      ld[k] = !(out_stall_i && ((v_q | mask) == {NST{1'b1}}));
    end
  end

  assign in_stall_o = !ld[0];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (ld[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NST; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  bdpc_alpha #(.CB(CB), .FB(FB)) u_alpha (
    .clk_i       (clk_i),
    .ld_i        (ld[4:0]),
    .dst_i       (dst),
    .dst_alpha_i (dst_alpha_i),
    .coverage_i  (coverage_i),
    .selected_i  (selected_i),
    .af_i        (af),
    .src_i       (src),
    .w_i         (w),
    .wn_i        (wn),
    .opacity_i   (opacity),
    .flow_i      (flow),
    .flags_i     (flags),
    .d_o         (d4),
    .da_o        (da4),
    .s_o         (s4),
    .dd_o        (dd4),
    .alpha_o     (alpha4),
    .ctl_o       (ctl4)
  );

  bdpc_blend #(.CB(CB), .FB(FB)) u_blend (
    .clk_i     (clk_i),
    .ld_i      (ld[6:5]),
    .d_i       (d4),
    .da_i      (da4),
    .s_i       (s4),
    .dd_i      (dd4),
    .alpha_i   (alpha4),
    .ctl_i     (ctl4),
    .pre_col_o (pre_col6),
    .pre_a_o   (pre_a6),
    .ctl_o     (ctl6),
    .num_o     (num6),
    .den_o     (den6)
  );

  assign side_in = {ctl6, pre_a6, pre_col6};

  bdpc_div #(.CB(CB), .FB(FB), .SW(SW)) u_div (
    .clk_i  (clk_i),
    .ld_i   (ld[NST-1:7]),
    .num_i  (num6),
    .den_i  (den6),
    .side_i (side_in),
    .quo_o  (quo),
    .side_o (side_out)
  );

  // Pick the quotient for a normal blend, else the precomputed pixel
  assign {ctl_out, pre_a_out, pre_col_out} = side_out;
  assign use_quo        = ctl_out.wr && (ctl_out.mode == MODE_NORMAL);
  assign out_red_o      = use_quo ? quo[0] : pre_col_out[0];
  assign out_green_o    = use_quo ? quo[1] : pre_col_out[1];
  assign out_blue_o     = use_quo ? quo[2] : pre_col_out[2];
  assign out_alpha_o    = pre_a_out;
  assign write_enable_o = ctl_out.wr;
  assign out_valid_o    = v_q[NST-1];

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&v_q) && out_stall_i))
    else $error("input stalled while pipeline has room");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted beat missing from first stage");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v_q[NST-2]) |=> !out_valid_o)
    else $error("output beat repeated");

  a_erase_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && write_enable_o && (ctl_out.mode == MODE_ERASE) && (out_alpha_o == '0))
      |-> ((out_red_o == '0) && (out_green_o == '0) && (out_blue_o == '0)))
    else $error("erased pixel kept colour at zero alpha");
`endif

endmodule
